// ===== hw/rtl/kpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad scanner: register indexes,
// reset values of the configuration registers and the lane hit record.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int MAX_DIM   = 4;
    localparam int IDX_W     = 2;
    localparam int CODE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_KEYMAP0  = 3'd1,
        CFG_KEYMAP1  = 3'd2,
        CFG_KEYMAP2  = 3'd3,
        CFG_KEYMAP3  = 3'd4
    } t_cfg_idx;

    localparam logic [CODE_W-1:0] DEBOUNCE_RESET = 8'd20;

    // "123A", "456B", "789C", "*0#D", byte c for column c
    localparam logic [CFG_DAT_W-1:0] KEYMAP_RESET [MAX_DIM] = '{
        32'h4133_3231,
        32'h4236_3534,
        32'h4339_3837,
        32'h4423_302A
    };

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] row;
    } t_hit;

endpackage

// ===== hw/rtl/kpd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_in_if
// Sample channel: row levels of the driven column and a timestamp.
// ----------------------------------------------------------------------------
interface kpd_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  row_levels;
    logic [31:0] now_ms;

    modport source (output valid, output row_levels, output now_ms, input ready);
    modport sink   (input valid, input row_levels, input now_ms, output ready);
endinterface

// ===== hw/rtl/kpd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_out_if
// Result channel: next column drive and the reported key, if any.
// ----------------------------------------------------------------------------
interface kpd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_drive;
    logic       key_valid;
    logic [7:0] key_code;
    logic [1:0] key_row;
    logic [1:0] key_column;

    modport source (output valid, output column_drive, output key_valid,
                    output key_code, output key_row, output key_column,
                    input ready);
    modport sink   (input valid, input column_drive, input key_valid,
                    input key_code, input key_row, input key_column,
                    output ready);
endinterface

// ===== hw/rtl/kpd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_lane
// One row of the matrix: holds seen level, stable level and change time of
// every key in the row, debounces the key of the sampled column.
// ----------------------------------------------------------------------------
module kpd_lane
    import kpd_pkg::*;
#(
    parameter int COLUMNS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_col,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CODE_W-1:0] i_debounce,
    input  logic              i_commit,
    output logic              o_press
);

    logic [COLUMNS-1:0] r_seen;
    logic [COLUMNS-1:0] r_stable;
    logic [TIME_W-1:0]  r_change [COLUMNS];

    logic              seen_old;
    logic              stable_old;
    logic [TIME_W-1:0] change_old;
    logic              changed;
    logic [TIME_W-1:0] elapsed;
    logic              flip;
    logic [TIME_W-1:0] n_change;

    always_comb begin
        seen_old   = 1'b0;
        stable_old = 1'b0;
        change_old = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            if (i_col == IDX_W'(c)) begin
                seen_old   = r_seen[c];
                stable_old = r_stable[c];
                change_old = r_change[c];
            end
        end
    end

    // a fresh change restarts the hold time, so it can never qualify now
    assign changed  = (i_level != seen_old);
    assign n_change = changed ? i_now : change_old;
    assign elapsed  = i_now - change_old;
    assign flip     = !changed && (elapsed > {{(TIME_W-CODE_W){1'b0}}, i_debounce})
                      && (stable_old != i_level);
    assign o_press  = flip && !i_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_stable <= '0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_change[c] <= '0;
            end
        end else if (i_commit) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (i_col == IDX_W'(c)) begin
                    r_seen[c]   <= i_level;
                    r_change[c] <= n_change;
                    if (flip) begin
                        r_stable[c] <= i_level;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/kpd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_merge
// Priority merge of the row lanes: the lowest pressed row wins, and rows
// above it keep their state for the next pass.
// ----------------------------------------------------------------------------
module kpd_merge
    import kpd_pkg::*;
#(
    parameter int ROWS = 4
) (
    input  logic            i_accept,
    input  logic [ROWS-1:0] i_press,
    output logic [ROWS-1:0] o_commit,
    output t_hit            o_hit
);

    always_comb begin
        o_hit = '0;
        for (int r = 0; r < ROWS; r++) begin
            o_commit[r] = i_accept && !o_hit.found;
            if (!o_hit.found && i_press[r]) begin
                o_hit.found = 1'b1;
                o_hit.row   = IDX_W'(r);
            end
        end
    end

endmodule

// ===== hw/rtl/matrix_keypad_scan_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// Scanner and per-key debouncer for an active-low key matrix.
// ----------------------------------------------------------------------------
// Each input word is one column sample and yields exactly one registered
// result word. The block takes one word per cycle while no result waits or
// the waiting result is consumed in the same cycle: all row lanes debounce
// their key of the sampled column, lanes up to the first pressed row write
// back its state, and the next word may sample any column. The first word
// samples column 0; after a reported press the scan restarts at column 0.
// The user writes configuration registers through the plain write port
// only when the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce
    import kpd_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    kpd_in_if.sink               i_in,
    kpd_out_if.source            o_out
);

    logic [CODE_W-1:0]    r_debounce;
    logic [CFG_DAT_W-1:0] r_keymap [MAX_DIM];
    logic [IDX_W-1:0]     r_col;

    logic                 r_ovalid;
    logic [3:0]           r_drive;
    logic                 r_kvalid;
    logic [CODE_W-1:0]    r_code;
    logic [IDX_W-1:0]     r_krow;
    logic [IDX_W-1:0]     r_kcol;

    logic                 in_acc;
    logic [ROWS-1:0]      press;
    logic [ROWS-1:0]      commit;
    t_hit                 hit;
    logic [IDX_W:0]       col_inc;
    logic [IDX_W-1:0]     n_col;
    logic [CFG_DAT_W-1:0] code_word;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        kpd_lane #(
            .COLUMNS (COLUMNS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_col      (r_col),
            .i_level    (i_in.row_levels[r]),
            .i_now      (i_in.now_ms),
            .i_debounce (r_debounce),
            .i_commit   (commit[r]),
            .o_press    (press[r])
        );
    end

    kpd_merge #(
        .ROWS (ROWS)
    ) u_merge (
        .i_accept (in_acc),
        .i_press  (press),
        .o_commit (commit),
        .o_hit    (hit)
    );

    assign col_inc   = {1'b0, r_col} + (IDX_W+1)'(1);
    assign n_col     = (hit.found || col_inc >= (IDX_W+1)'(COLUMNS))
                       ? '0 : col_inc[IDX_W-1:0];
    assign code_word = r_keymap[hit.row] >> {r_col, 3'b000};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            for (int r = 0; r < MAX_DIM; r++) begin
                r_keymap[r] <= KEYMAP_RESET[r];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce  <= i_cfg_wdata[CODE_W-1:0];
                CFG_KEYMAP0:  r_keymap[0] <= i_cfg_wdata;
                CFG_KEYMAP1:  r_keymap[1] <= i_cfg_wdata;
                CFG_KEYMAP2:  r_keymap[2] <= i_cfg_wdata;
                CFG_KEYMAP3:  r_keymap[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan position and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col    <= n_col;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_drive  <= ~(4'b0001 << n_col);
            r_kvalid <= hit.found;
            r_code   <= hit.found ? code_word[CODE_W-1:0] : '0;
            r_krow   <= hit.found ? hit.row : '0;
            r_kcol   <= hit.found ? r_col : '0;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.column_drive = r_drive;
    assign o_out.key_valid    = r_kvalid;
    assign o_out.key_code     = r_code;
    assign o_out.key_row      = r_krow;
    assign o_out.key_column   = r_kcol;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IDX_W+1)'(r_col) < (IDX_W+1)'(COLUMNS))
        else $error("scan column out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && hit.found |=> r_col == '0 && o_out.column_drive == 4'b1110)
        else $error("scan did not restart after a press");

    a_drive_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.column_drive == ~(4'b0001 << r_col))
        else $error("column drive does not match scan position");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.key_valid |->
        o_out.key_code == '0 && o_out.key_row == '0 && o_out.key_column == '0)
        else $error("key fields set without a report");

    a_commit_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |-> commit == '0)
        else $error("key state written without an accepted word");

endmodule

// ===== verif/matrix_keypad_scan_debounce_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_test
// Self-checking bench for the keypad scanner. It feeds column samples taken
// from a modeled 4x4 keypad with contact bounce, plus raw noise and
// timestamp jumps. It predicts every result word, including the column
// drive, the debounced press reports and their key codes, and compares
// each word field by field. The debounce time and the keymaps are swept
// across several settings, the extremes among them.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_test;
    import kpd_pkg::*;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic [1:0] key_row;
        logic [1:0] key_column;
    } t_key_report;

    class keypad_scoreboard;
        logic [7:0]  hold_ms;
        logic [31:0] keymap [4];
        logic        seen [16];
        logic        stable [16];
        logic [31:0] changed_at [16];
        logic [1:0]  column;
        t_key_report pending [$];
        int          errors;

        function new();
            hold_ms = DEBOUNCE_RESET;
            keymap  = KEYMAP_RESET;
            foreach (seen[k]) begin
                seen[k]       = 1'b0;
                stable[k]     = 1'b0;
                changed_at[k] = '0;
            end
            column = '0;
            errors = 0;
        endfunction

        function void apply_write(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_DEBOUNCE: hold_ms   = data[7:0];
                CFG_KEYMAP0:  keymap[0] = data;
                CFG_KEYMAP1:  keymap[1] = data;
                CFG_KEYMAP2:  keymap[2] = data;
                CFG_KEYMAP3:  keymap[3] = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [3:0] levels, logic [31:0] stamp);
            t_key_report want;
            logic [31:0] elapsed;
            int          k;
            want = '0;
            for (int r = 0; r < 4; r++) begin
                k = r * 4 + column;
                if (levels[r] != seen[k]) begin
                    changed_at[k] = stamp;
                    seen[k]       = levels[r];
                end
                // elapsed time wraps modulo 2^32
                elapsed = stamp - changed_at[k];
                if (elapsed > hold_ms && stable[k] != levels[r]) begin
                    stable[k] = levels[r];
                    if (!levels[r]) begin
                        // report the first newly pressed row, leave the rest for a later pass
                        want.key_valid  = 1'b1;
                        want.key_code   = keymap[r][8 * column +: 8];
                        want.key_row    = 2'(r);
                        want.key_column = column;
                        break;
                    end
                end
            end
            column = want.key_valid ? 2'd0 : column + 2'd1;
            want.column_drive = ~(4'b0001 << column);
            pending.push_back(want);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_key_report got);
            t_key_report want;
            if (pending.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("column_drive", want.column_drive, got.column_drive);
            compare_field("key_valid", want.key_valid, got.key_valid);
            compare_field("key_code", want.key_code, got.key_code);
            compare_field("key_row", want.key_row, got.key_row);
            compare_field("key_column", want.key_column, got.key_column);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    kpd_in_if  sample_ch ();
    kpd_out_if report_ch ();

    matrix_keypad_scan_debounce DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (sample_ch),
        .o_out       (report_ch)
    );

    keypad_scoreboard sb;
    logic [15:0]      pressed_keys;
    logic [31:0]      sim_ms;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic send_sample(input logic [3:0] levels, input logic [31:0] stamp);
        sample_ch.valid      <= 1'b1;
        sample_ch.row_levels <= levels;
        sample_ch.now_ms     <= stamp;
        do @(posedge i_clk); while (!(sample_ch.valid && sample_ch.ready));
        sb.note_sample(levels, stamp);
    endtask

    task automatic configure(input logic [31:0] values [5]);
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= values[i];
            @(posedge i_clk);
            sb.apply_write(t_cfg_idx'(i), values[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int         burst_left;
        int         k;
        int         step_max;
        logic [3:0] levels;
        logic [1:0] col;
        burst_left = 0;
        step_max   = sb.hold_ms / 3 + 2;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) begin
                    sample_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            burst_left--;
            sim_ms += $urandom_range(0, step_max);
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 15);
                pressed_keys[k] = ~pressed_keys[k];
            end
            if ($urandom_range(0, 6) == 0) begin
                // noise word, sometimes with a jump of the timestamp
                levels = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 3) == 0) sim_ms = $urandom();
            end else begin
                // sample the keypad at the column the scanner drives, with bounce
                col = sb.column;
                for (int r = 0; r < 4; r++)
                    levels[r] = ~pressed_keys[r * 4 + col] ^ ($urandom_range(0, 11) == 0);
            end
            send_sample(levels, sim_ms);
        end
        sample_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_key_report got;
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            got = {report_ch.column_drive, report_ch.key_valid, report_ch.key_code,
                   report_ch.key_row, report_ch.key_column};
            sb.check_result(got);
        end
    end

    // receiver: runs of full rate, random ready and long stalls
    initial begin
        report_ch.ready <= 1'b0;
        forever begin
            int mode;
            int len;
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0:       report_ch.ready <= 1'b1;
                    1:       report_ch.ready <= 1'($urandom_range(0, 1));
                    default: report_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [31:0] regs [5];
        sb = new();
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_DEBOUNCE;
        i_cfg_wdata          <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.row_levels <= 4'hF;
        sample_ch.now_ms     <= '0;
        pressed_keys = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keys held low since reset must stay silent, across the timestamp wrap
        send_sample(4'h0, 32'hFFFF_FFFF);
        sim_ms = '0;
        repeat (5) begin
            send_sample(4'h0, sim_ms);
            sim_ms += 10;
        end
        // release everything, then press everything: row priority decides
        repeat (8) begin
            send_sample(4'hF, sim_ms);
            sim_ms += 10;
        end
        repeat (12) begin
            send_sample(4'h0, sim_ms);
            sim_ms += 10;
        end
        sim_ms = 32'hFFFF_F000;
        run_random(220);
        drain();

        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: regs = '{32'd0, 32'h0, 32'h0, 32'h0, 32'h0};
                2: regs = '{32'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF};
                3: regs = '{32'd1, $urandom(), $urandom(), $urandom(), $urandom()};
                4: regs = '{32'($urandom_range(2, 254)), $urandom() & 32'hFFFF_00FF,
                            $urandom() & 32'h00FF_FFFF, $urandom(), $urandom() & 32'hFF00_FFFF};
                default: regs = '{{24'b0, DEBOUNCE_RESET}, KEYMAP_RESET[0], KEYMAP_RESET[1],
                                  KEYMAP_RESET[2], KEYMAP_RESET[3]};
            endcase
            configure(regs);
            run_random(250);
            drain();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
